// File: rtl/cem_pkg.sv
// ---------------------------------------------------------------------------
// cem_pkg: shared types and helpers for the corrected error median block
// Sizes, item and result words, controller/datapath command and status
// structs, and the saturating add used by both the lanes and the median.
// ---------------------------------------------------------------------------
`default_nettype none

package cem_pkg;

	localparam int HIST_DEPTH = 16;
	localparam int VALUE_W    = 48;
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   action;
		value_t correction;
		value_t new_error;
	} item_t;

	typedef struct packed {
		logic             median_valid;
		value_t           median_error;
		logic [CNT_W-1:0] sample_count;
	} result_t;

	typedef struct packed {
		logic             update;
		logic             load;
		logic [IDX_W-1:0] slot;
		logic             finish;
	} cem_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
	} cem_status_t;

	// add with saturation at the signed value limits
	function automatic value_t sat_add(input value_t a, input value_t b);
		logic [VALUE_W:0] s;
		value_t           r;
		s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
		if (s[VALUE_W] != s[VALUE_W-1]) begin
			r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			r = s[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/cem_dp.sv
// ---------------------------------------------------------------------------
// cem_dp: history lanes, rank pipeline and result register
// Holds the newest samples in a shift line, ranks one candidate per cycle
// against all lanes, captures the two middle values and forms the median.
// ---------------------------------------------------------------------------
`default_nettype none

module cem_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cem_pkg::cem_cmd_t cmd,
	input  wire cem_pkg::item_t    item,
	output cem_pkg::cem_status_t   status,
	output cem_pkg::result_t       result
);
	import cem_pkg::*;

	value_t           h_q [HIST_DEPTH];
	logic [CNT_W-1:0] cnt_q;

	value_t           cand_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             v_s1;
	value_t           cand_s2;
	logic [HIST_DEPTH-1:0] lt_s2;
	logic             v_s2;
	logic [HIST_DEPTH-1:0] lt;

	value_t           lo_q;
	value_t           hi_q;
	result_t          result_q;

	logic [CNT_W-1:0] rank;
	logic [CNT_W-1:0] hi_t;
	logic [CNT_W-1:0] lo_t;
	value_t           med;

	assign status.cnt = cnt_q;
	assign result     = result_q;

	// history lanes: newest at lane 0, older lanes take the corrected neighbor
	always_ff @(posedge clk) begin
		if (cmd.update && item.action == ACT_RECORD) begin
			h_q[0] <= item.new_error;
			for (int j = 1; j < HIST_DEPTH; j++) begin
				h_q[j] <= sat_add(h_q[j-1], item.correction);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd.update) begin
				if (item.action == ACT_CLEAR) begin
					cnt_q <= '0;
				end else if (cnt_q != CNT_W'(HIST_DEPTH)) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			v_s1 <= cmd.load;
			v_s2 <= v_s1;
		end
	end

	// compare candidate against every held lane; ties broken by lane index
	always_comb begin
		for (int j = 0; j < HIST_DEPTH; j++) begin
			lt[j] = (CNT_W'(j) < cnt_q) &&
				((h_q[j] < cand_s1) || ((h_q[j] == cand_s1) && (IDX_W'(j) < idx_s1)));
		end
	end

	always_comb begin
		rank = '0;
		for (int j = 0; j < HIST_DEPTH; j++) begin
			rank = rank + CNT_W'(lt_s2[j]);
		end
	end

	assign hi_t = cnt_q >> 1;
	assign lo_t = hi_t - CNT_W'(1);

	always_comb begin
		if (cnt_q == '0) begin
			med = '0;
		end else if (cnt_q[0]) begin
			med = hi_q;
		end else begin
			med = sat_add(lo_q, hi_q) >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_s1 <= h_q[cmd.slot];
			idx_s1  <= cmd.slot;
		end
		cand_s2 <= cand_s1;
		lt_s2   <= lt;
		if (v_s2) begin
			if (rank == lo_t) begin
				lo_q <= cand_s2;
			end
			if (rank == hi_t) begin
				hi_q <= cand_s2;
			end
		end
		if (cmd.finish) begin
			result_q.median_valid <= (cnt_q != '0);
			result_q.median_error <= med;
			result_q.sample_count <= cnt_q;
		end
	end

endmodule

`default_nettype wire

// File: rtl/cem_ctrl.sv
// ---------------------------------------------------------------------------
// cem_ctrl: sequencer for the corrected error median block
// Accepts a word, walks the rank scan over the held samples, drains the
// rank pipeline and loads the result register when the output is free.
// ---------------------------------------------------------------------------
`default_nettype none

module cem_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	input  wire cem_pkg::cem_status_t status,
	output cem_pkg::cem_cmd_t         cmd
);
	import cem_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] slot_q;
	logic             drain_q;
	logic             out_q;
	logic             fin_go;
	logic             last_slot;

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_q;
	assign fin_go       = (state_q == ST_FIN) && (!out_q || !result_stall);
	assign last_slot    = (CNT_W'(slot_q) == status.cnt - CNT_W'(1));

	assign cmd.update = (state_q == ST_IDLE) && item_valid;
	assign cmd.load   = (state_q == ST_SCAN);
	assign cmd.slot   = slot_q;
	assign cmd.finish = fin_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
			drain_q <= 1'b0;
			out_q   <= 1'b0;
		end else begin
			if (fin_go) begin
				out_q <= 1'b1;
			end else if (out_q && !result_stall) begin
				out_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					slot_q  <= '0;
					drain_q <= 1'b0;
					state_q <= (status.cnt == '0) ? ST_FIN : ST_SCAN;
				end
				ST_SCAN: begin
					slot_q <= slot_q + IDX_W'(1);
					if (last_slot) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/corrected_error_median_core.sv
// A word is taken only in the idle state; the block then stays busy until
// its result word is loaded, so it cannot take a new word before that.
// The rank scan visits one held sample per cycle.
// Reset: arst_n clears the sample count, the sequencer and the output valid;
//   history lanes hold no reset value and are read only once written.
// ---------------------------------------------------------------------------
// corrected_error_median_core: running median of corrected clock errors
// A record word adds its correction (saturating) to every held sample and
// shifts in the new sample; a clear word empties the history. After every
// word one result word gives the median of the held samples and the count.
// ---------------------------------------------------------------------------
`default_nettype none

module corrected_error_median_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire cem_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cem_pkg::result_t      result
);
	import cem_pkg::*;

	cem_cmd_t    cmd;
	cem_status_t status;

	// sequencer: accept, scan each held sample once, drain the rank pipe,
	// then load the result register when the previous word has left
	cem_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// datapath: history shift line with per-lane saturating correction,
	// rank compare against all lanes, middle-value capture, median output
	cem_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

`ifndef SYNTH
	// an accepted word keeps the block busy on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("block took a word without going busy");

	// the reported count never exceeds the history depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.sample_count <= CNT_W'(HIST_DEPTH)))
		else $error("sample count beyond history depth");

	// the median is flagged valid exactly when samples are held
	a_median_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.median_valid == (result.sample_count != '0)))
		else $error("median flag disagrees with sample count");

	// an empty history reports a zero median
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.median_valid) |-> (result.median_error == '0))
		else $error("empty history gave a nonzero median");
`endif

endmodule

`default_nettype wire

// File: tb/sv/corrected_error_median_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// corrected_error_median_core_tb: self-checking bench for the median core
// Walks a short table of hand-picked words, then about a thousand random
// words under four idling patterns, and checks every result word against a
// hand-picked expectation or a behavioral predictor of the corrected sample history.
// ---------------------------------------------------------------------------

module corrected_error_median_core_tb;

	import cem_pkg::*;

	localparam value_t VMAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam value_t VMIN = {1'b1, {(VALUE_W-1){1'b0}}};
	// one result per word
	localparam int TAIL_CYCLES    = 2 * HIST_DEPTH + 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int PRESSURE_WORDS = 12;
	localparam int PHASE_WORDS    = 250;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_CAP      = 200;

	typedef struct {
		item_t   w;
		bit      fixed;
		result_t want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	// predictor state: the corrected samples held since the last clear
	value_t      hist [HIST_DEPTH];
	int unsigned next_slot;
	bit          still_filling;

	result_t   median_q [$];
	stim_row_t directed_rows [$];

	int gap_pct;
	int stall_pct;
	bit hold_request;
	int mismatch_count;
	int quiet_cycles;

	corrected_error_median_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------

	// signed add, pinned to the value range on overflow
	function automatic value_t clamped_sum(input value_t a, input value_t b);
		logic signed [VALUE_W:0] s;
		s = a + b;
		if (s > VMAX)
			return VMAX;
		if (s < VMIN)
			return VMIN;
		return s[VALUE_W-1:0];
	endfunction

	function automatic int held_samples();
		return still_filling ? int'(next_slot) : HIST_DEPTH;
	endfunction

	function automatic result_t outcome(input logic ok, input value_t med, input int n);
		result_t r;
		r.median_valid = ok;
		r.median_error = med;
		r.sample_count = n[CNT_W-1:0];
		return r;
	endfunction

	// apply one word to the history and return the median word it yields
	function automatic result_t advance_history(input item_t w);
		value_t ranked [HIST_DEPTH];
		value_t v;
		int     n;
		int     j;
		if (w.action == ACT_CLEAR) begin
			next_slot     = 0;
			still_filling = 1'b1;
		end else begin
			n = held_samples();
			for (int i = 0; i < n; i++)
				hist[i] = clamped_sum(hist[i], w.correction);
			hist[next_slot] = w.new_error;
			next_slot++;
			if (next_slot == HIST_DEPTH) begin
				next_slot     = 0;
				still_filling = 1'b0;
			end
		end
		n = held_samples();
		// insertion sort, ascending
		for (int i = 0; i < n; i++) begin
			v = hist[i];
			j = i;
			while (j > 0 && ranked[j-1] > v) begin
				ranked[j] = ranked[j-1];
				j--;
			end
			ranked[j] = v;
		end
		if (n == 0)
			return outcome(1'b0, '0, 0);
		if (n % 2 == 0)
			// arithmetic shift floors toward minus infinity
			return outcome(1'b1, clamped_sum(ranked[n/2-1], ranked[n/2]) >>> 1, n);
		return outcome(1'b1, ranked[n/2], n);
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus helpers
	// -----------------------------------------------------------------------

	function automatic value_t random_value(input bit mild);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(mild ? 15 : 9))
			0:       return VMAX;
			1:       return VMIN;
			2, 3, 4: return {{(VALUE_W-16){raw[15]}}, raw[15:0]};
			5:       return '0;
			default: begin
				if (mild)
					return value_t'({{(VALUE_W-16){raw[15]}}, raw[15:0]}) >>> 4;
				return raw[VALUE_W-1:0];
			end
		endcase
	endfunction

	// mostly records, so the ring fills and wraps; a clear now and then
	function automatic item_t random_word();
		item_t w;
		w.action     = ($urandom_range(19) == 0) ? ACT_CLEAR : ACT_RECORD;
		// keep corrections mostly small so medians do not all pin at the limits
		w.correction = ($urandom_range(7) == 0) ? random_value(1'b0) : random_value(1'b1);
		w.new_error  = random_value(1'b0);
		return w;
	endfunction

	task automatic add_row(input logic act, input value_t corr, input value_t ne,
	                       input bit fixed, input result_t want);
		stim_row_t row;
		row.w.action     = act;
		row.w.correction = corr;
		row.w.new_error  = ne;
		row.fixed        = fixed;
		row.want         = want;
		directed_rows.push_back(row);
	endtask

	task automatic load_table();
		value_t corr;
		value_t ne;
		// clear on an empty history, junk in the ignored fields
		add_row(ACT_CLEAR,  VMAX, VMIN, 1'b1, outcome(1'b0, '0, 0));
		add_row(ACT_RECORD, '0,   VMAX, 1'b1, outcome(1'b1, VMAX, 1));
		// correction saturates high; even count of the two limits floors to -1
		add_row(ACT_RECORD, VMAX, VMIN, 1'b1, outcome(1'b1, -48'sd1, 2));
		// correction saturates low
		add_row(ACT_RECORD, VMIN, '0,   1'b1, outcome(1'b1, -48'sd1, 3));
		add_row(ACT_CLEAR,  VMIN, VMAX, 1'b1, outcome(1'b0, '0, 0));
		add_row(ACT_RECORD, VMIN, VMIN, 1'b1, outcome(1'b1, VMIN, 1));
		// median sum saturates low before halving
		add_row(ACT_RECORD, '0,   VMIN, 1'b1, outcome(1'b1, VMIN >>> 1, 2));
		add_row(ACT_RECORD, -48'sd1, VMAX, 1'b1, outcome(1'b1, VMIN, 3));
		// fill the ring and wrap it once
		for (int k = 0; k < 14; k++) begin
			corr = k[0] ? 48'sd65536 : -48'sd32768;
			ne   = k[0] ? value_t'(k * 1000003) : -value_t'(k * 777777);
			add_row(ACT_RECORD, corr, ne, 1'b0, '0);
		end
		add_row(ACT_CLEAR,  '1,   '1,   1'b1, outcome(1'b0, '0, 0));
		add_row(ACT_RECORD, VMAX, '0,   1'b1, outcome(1'b1, '0, 1));
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_word(input item_t w, input bit fixed, input result_t want);
		result_t predicted;
		while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do
			@(posedge clk);
		while (item_stall);
		predicted = advance_history(w);
		median_q.push_back(fixed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic wait_for_medians();
		while (median_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic flag_mismatch(input string what, input logic [63:0] got,
	                             input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
	endtask

	// -----------------------------------------------------------------------
	// Receiver: random stall per cycle, or one long hold-off on request
	// -----------------------------------------------------------------------
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				// count the hold-off here, not in the sender
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
			end
		end
	end

	// -----------------------------------------------------------------------
	// Checker: compare each accepted result word with the oldest prediction
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (median_q.size() == 0) begin
				flag_mismatch("result word with nothing pending", 64'(result), '0);
			end else begin
				want = median_q.pop_front();
				if (result.median_valid !== want.median_valid)
					flag_mismatch("median_valid", 64'(result.median_valid),
					              64'(want.median_valid));
				if (result.median_error !== want.median_error)
					flag_mismatch("median_error", 64'(result.median_error),
					              64'(want.median_error));
				if (result.sample_count !== want.sample_count)
					flag_mismatch("sample_count", 64'(result.sample_count),
					              64'(want.sample_count));
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		gap_pct        = 0;
		stall_pct      = 0;
		hold_request   = 1'b0;
		mismatch_count = 0;
		next_slot      = 0;
		still_filling  = 1'b1;
		load_table();

		// hold reset, then release it on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, back to back
		foreach (directed_rows[r])
			offer_word(directed_rows[r].w, directed_rows[r].fixed, directed_rows[r].want);
		item_valid <= 1'b0;
		wait_for_medians();

		// hold off the receiver while the sender keeps offering, so the core
		// backs up and stalls its input; then pause until everything drains
		hold_request = 1'b1;
		repeat (PRESSURE_WORDS)
			offer_word(random_word(), 1'b0, '0);
		item_valid <= 1'b0;
		wait_for_medians();

		// random words under each idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 77; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 77; end
				default: begin gap_pct = 10; stall_pct = 10; end
			endcase
			repeat (PHASE_WORDS)
				offer_word(random_word(), 1'b0, '0);
			item_valid <= 1'b0;
			wait_for_medians();
		end

		// let any straggling result word show up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/cem_pkg.sv
rtl/cem_dp.sv
rtl/cem_ctrl.sv
rtl/corrected_error_median_core.sv
tb/sv/corrected_error_median_core_tb.sv
